// File: hw/rtl/tqfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqfr_pkg: shared definitions for the two-queue frame replacement block
// Sizes, request, tag and error codes, list descriptors and the list helpers
// used by the replacement sequencer.
// ----------------------------------------------------------------------------
package tqfr_pkg;

  // Frame numbering. The frame field is ten bits wide, so every frame number
  // addresses one entry of the per-frame stores.
  localparam int FRAME_W    = 10;
  localparam int NUM_FRAMES = 2 ** FRAME_W;
  localparam int CNT_W      = FRAME_W + 1;
  localparam int CAP_W      = 11;
  localparam int RES_W      = CNT_W + 1;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [RES_W-1:0]   res_cnt_t;

  // Register indexes, taken from the word address.
  localparam logic REG_COLD_CAP = 1'b0;
  localparam logic REG_HOT_CAP  = 1'b1;

  localparam cap_t COLD_CAP_RST = CAP_W'(256);
  localparam cap_t HOT_CAP_RST  = CAP_W'(768);

  typedef enum logic [1:0] {
    REQ_HIT     = 2'd0,
    REQ_FILL    = 2'd1,
    REQ_RECYCLE = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_COLD = 2'd1,
    TAG_HOT  = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_MISS  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // Head, tail and length of one doubly linked list.
  typedef struct packed {
    frame_t head;
    frame_t tail;
    cnt_t   cnt;
  } list_t;

  // Neighbour link updates caused by taking one frame out of a list.
  typedef struct packed {
    logic   lt_we;
    frame_t lt_addr;
    frame_t lt_data;
    logic   lh_we;
    frame_t lh_addr;
    frame_t lh_data;
  } link_wr_t;

  // One result item.
  typedef struct packed {
    frame_t   assigned_frame;
    logic     evict_valid;
    frame_t   evicted_frame;
    logic     evicted_from_hot;
    err_t     error_code;
    res_cnt_t resident_count;
  } res_t;

  // A capacity of zero behaves as a capacity of one.
  function automatic cap_t eff_cap(cap_t cap);
    return (cap == '0) ? CAP_W'(1) : cap;
  endfunction

  function automatic logic list_full(list_t l, cap_t cap);
    return (l.cnt != '0) && (CAP_W'(l.cnt) >= eff_cap(cap));
  endfunction

  // New ends and length after frame f, with neighbours p and n, leaves.
  function automatic list_t unlink_list(list_t l, frame_t f, frame_t p, frame_t n);
    list_t r;
    r = l;
    if (f == l.head) r.head = n;
    if (f == l.tail) r.tail = p;
    if (l.cnt != '0) r.cnt = l.cnt - CNT_W'(1);
    return r;
  endfunction

  // Links of the neighbours that must be patched around frame f.
  function automatic link_wr_t unlink_wr(list_t l, frame_t f, frame_t p, frame_t n);
    link_wr_t w;
    w.lt_we   = (f != l.head);
    w.lt_addr = p;
    w.lt_data = n;
    w.lh_we   = (f != l.tail);
    w.lh_addr = n;
    w.lh_data = p;
    return w;
  endfunction

  function automatic res_cnt_t resident(list_t c, list_t h);
    return {1'b0, c.cnt} + {1'b0, h.cnt};
  endfunction

endpackage

// File: hw/rtl/two_queue_frame_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_frame_replacement: 2Q replacement over buffer frame numbers
// A cold FIFO list and a hot LRU list are kept as doubly linked lists in
// per-frame link memories, with a per-frame membership tag memory.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                    Payload
//  in       input      in_valid / in_stall          in_req_type, in_frame_number
//  out      output     out_valid / out_stall        out_assigned_frame ...
//                                                   out_resident_count
//  cfg      input      psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  An error or no-op item finishes in S_FIRST; a hot hit, or a fill or cold
//  hit without eviction, goes on to S_PUSH; an eviction of a tail frame or a
//  cold recycle goes through S_VICT before S_PUSH. The dependent reads of the
//  single-port-read link memories set these steps: tag and links first, then
//  the victim's. After reset every tag entry is cleared, one entry a cycle;
//  no item is accepted meanwhile, configuration writes are taken as ever.
//  A result waits in the output register while the next item is accepted;
//  an item finishes only once the previous result has been taken.
//
module two_queue_frame_replacement (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  tqfr_pkg::frame_t            in_frame_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tqfr_pkg::frame_t            out_assigned_frame,
  output logic                        out_evict_valid,
  output tqfr_pkg::frame_t            out_evicted_frame,
  output logic                        out_evicted_from_hot,
  output logic [1:0]                  out_error_code,
  output tqfr_pkg::res_cnt_t          out_resident_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tqfr_pkg::PADDR_W-1:0] paddr,
  input  logic [tqfr_pkg::PDATA_W-1:0] pwdata,
  output logic [tqfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tqfr_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FIRST = 5'b00100,
    S_VICT  = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  frame_t clr_idx_r;
  list_t  cold_r, cold_nxt;
  list_t  hot_r, hot_nxt;
  cap_t   cold_cap_r, hot_cap_r;

  // Item context.
  req_t   type_r;
  frame_t fn_r;
  frame_t op_frame_r, op_frame_nxt;
  logic   push_hot_r, push_hot_nxt;
  logic   ev_valid_r, ev_valid_nxt;
  frame_t ev_frame_r, ev_frame_nxt;
  logic   ev_hot_r, ev_hot_nxt;

  // Output register.
  res_t   res_r, res_nxt;
  logic   res_load;
  logic   out_valid_r;
  logic   out_free;

  // Memory ports.
  logic [1:0] tag_mem [NUM_FRAMES];
  frame_t     lh_mem  [NUM_FRAMES];
  frame_t     lt_mem  [NUM_FRAMES];
  frame_t     rd_addr;
  logic       tag_re, link_re;
  logic       tag_we, lh_we, lt_we;
  frame_t     tag_wa, lh_wa, lt_wa;
  logic [1:0] tag_wd;
  frame_t     lh_wd, lt_wd;
  logic [1:0] tag_q_r, tag_bd_r, tag_rd;
  logic       tag_hit_r, lh_hit_r, lt_hit_r;
  frame_t     lh_q_r, lh_bd_r, lh_rd;
  frame_t     lt_q_r, lt_bd_r, lt_rd;

  logic cfg_wr;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Read data with the write of the same cycle forwarded.
  assign tag_rd = tag_hit_r ? tag_bd_r : tag_q_r;
  assign lh_rd  = lh_hit_r  ? lh_bd_r  : lh_q_r;
  assign lt_rd  = lt_hit_r  ? lt_bd_r  : lt_q_r;

  // Sequencer: unlink the requested frame, unlink a tail victim, push.
  always_comb begin
    logic       in_range;
    logic [1:0] tag_eff;
    logic       unl_en, unl_hot, go_push, chk_full, recycle, fin, victim;
    err_t       fin_err;
    list_t      sel_l, new_l, tgt_l;
    link_wr_t   uw;

    state_nxt    = state_r;
    cold_nxt     = cold_r;
    hot_nxt      = hot_r;
    op_frame_nxt = op_frame_r;
    push_hot_nxt = push_hot_r;
    ev_valid_nxt = ev_valid_r;
    ev_frame_nxt = ev_frame_r;
    ev_hot_nxt   = ev_hot_r;
    res_nxt      = res_r;
    res_load     = 1'b0;
    rd_addr      = in_frame_number;
    tag_re       = 1'b0;
    link_re      = 1'b0;
    tag_we       = 1'b0;
    tag_wa       = fn_r;
    tag_wd       = TAG_NONE;
    lh_we        = 1'b0;
    lh_wa        = fn_r;
    lh_wd        = fn_r;
    lt_we        = 1'b0;
    lt_wa        = fn_r;
    lt_wd        = fn_r;
    in_range     = ({1'b0, fn_r} < CNT_W'(NUM_FRAMES));
    tag_eff      = in_range ? tag_rd : TAG_NONE;
    unl_en       = 1'b0;
    unl_hot      = 1'b0;
    go_push      = 1'b0;
    chk_full     = 1'b0;
    recycle      = 1'b0;
    fin          = 1'b0;
    fin_err      = ERR_OK;
    victim       = 1'b0;
    sel_l        = cold_r;
    new_l        = cold_r;
    tgt_l        = cold_r;
    uw           = '0;

    case (state_r)
      S_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = clr_idx_r;
        tag_wd = TAG_NONE;
        if (clr_idx_r == frame_t'(NUM_FRAMES - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          tag_re    = 1'b1;
          link_re   = 1'b1;
          state_nxt = S_FIRST;
        end
      end

      S_FIRST: begin
        // Work out what this item does from the frame's tag.
        case (type_r)
          REQ_HIT: begin
            if (tag_eff == TAG_HOT) begin
              unl_en  = 1'b1;
              unl_hot = 1'b1;
              go_push = 1'b1;
            end else if (tag_eff == TAG_COLD) begin
              unl_en   = 1'b1;
              go_push  = 1'b1;
              chk_full = 1'b1;
            end else begin
              fin     = 1'b1;
              fin_err = ERR_MISS;
            end
          end
          REQ_FILL, REQ_RECYCLE: begin
            if (type_r == REQ_FILL && in_range) begin
              unl_en   = (tag_eff == TAG_COLD) || (tag_eff == TAG_HOT);
              unl_hot  = (tag_eff == TAG_HOT);
              go_push  = 1'b1;
              chk_full = 1'b1;
            end else if (cold_r.cnt == '0) begin
              fin     = 1'b1;
              fin_err = ERR_EMPTY;
            end else begin
              go_push = 1'b1;
              recycle = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase

        // Take the requested frame out of its list.
        sel_l = unl_hot ? hot_r : cold_r;
        new_l = unlink_list(sel_l, fn_r, lh_rd, lt_rd);
        uw    = unlink_wr(sel_l, fn_r, lh_rd, lt_rd);
        if (unl_en) begin
          if (unl_hot) hot_nxt = new_l;
          else cold_nxt = new_l;
          lt_we  = uw.lt_we;
          lt_wa  = uw.lt_addr;
          lt_wd  = uw.lt_data;
          lh_we  = uw.lh_we;
          lh_wa  = uw.lh_addr;
          lh_wd  = uw.lh_data;
          tag_we = 1'b1;
          tag_wa = fn_r;
          tag_wd = TAG_NONE;
        end

        // A hit goes to the hot list; fills and recycles go to the cold list.
        tgt_l  = (type_r == REQ_HIT) ? hot_nxt : cold_nxt;
        victim = recycle ||
                 (chk_full && list_full(tgt_l, (type_r == REQ_HIT) ? hot_cap_r : cold_cap_r));

        if (go_push) begin
          op_frame_nxt = recycle ? tgt_l.tail : fn_r;
          push_hot_nxt = (type_r == REQ_HIT);
          ev_valid_nxt = victim;
          ev_frame_nxt = tgt_l.tail;
          ev_hot_nxt   = (type_r == REQ_HIT);
          if (victim) begin
            link_re   = 1'b1;
            rd_addr   = tgt_l.tail;
            state_nxt = S_VICT;
          end else begin
            state_nxt = S_PUSH;
          end
        end else if (fin && out_free) begin
          res_nxt.assigned_frame   = '0;
          res_nxt.evict_valid      = 1'b0;
          res_nxt.evicted_frame    = '0;
          res_nxt.evicted_from_hot = 1'b0;
          res_nxt.error_code       = fin_err;
          res_nxt.resident_count   = resident(cold_r, hot_r);
          res_load                 = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      S_VICT: begin
        // Remove the tail victim whose links were read last cycle.
        sel_l = ev_hot_r ? hot_r : cold_r;
        new_l = unlink_list(sel_l, ev_frame_r, lh_rd, lt_rd);
        uw    = unlink_wr(sel_l, ev_frame_r, lh_rd, lt_rd);
        if (ev_hot_r) hot_nxt = new_l;
        else cold_nxt = new_l;
        lt_we     = uw.lt_we;
        lt_wa     = uw.lt_addr;
        lt_wd     = uw.lt_data;
        lh_we     = uw.lh_we;
        lh_wa     = uw.lh_addr;
        lh_wd     = uw.lh_data;
        tag_we    = 1'b1;
        tag_wa    = ev_frame_r;
        tag_wd    = TAG_NONE;
        state_nxt = S_PUSH;
      end

      S_PUSH: begin
        // Insert at the head. The head's toward-head link is never followed,
        // so only the old head and the new frame get link writes.
        if (out_free) begin
          sel_l = push_hot_r ? hot_r : cold_r;
          new_l = sel_l;
          if (sel_l.cnt == '0) begin
            new_l.tail = op_frame_r;
          end else begin
            lt_we = 1'b1;
            lt_wa = op_frame_r;
            lt_wd = sel_l.head;
            lh_we = 1'b1;
            lh_wa = sel_l.head;
            lh_wd = op_frame_r;
          end
          new_l.head = op_frame_r;
          new_l.cnt  = sel_l.cnt + CNT_W'(1);
          tag_we     = 1'b1;
          tag_wa     = op_frame_r;
          tag_wd     = push_hot_r ? TAG_HOT : TAG_COLD;
          if (push_hot_r) hot_nxt = new_l;
          else cold_nxt = new_l;

          res_nxt.assigned_frame   = op_frame_r;
          res_nxt.evict_valid      = ev_valid_r;
          res_nxt.evicted_frame    = ev_valid_r ? ev_frame_r : '0;
          res_nxt.evicted_from_hot = ev_valid_r && ev_hot_r;
          res_nxt.error_code       = ERR_OK;
          res_nxt.resident_count   = resident(cold_nxt, hot_nxt);
          res_load                 = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control state and configuration.
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      cold_r      <= '0;
      hot_r       <= '0;
      cold_cap_r  <= COLD_CAP_RST;
      hot_cap_r   <= HOT_CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cold_r  <= cold_nxt;
      hot_r   <= hot_nxt;
      if (state_r == S_CLEAR) clr_idx_r <= clr_idx_r + FRAME_W'(1);
      if (res_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        case (paddr[2])
          REG_COLD_CAP: cold_cap_r <= pwdata[CAP_W-1:0];
          REG_HOT_CAP:  hot_cap_r  <= pwdata[CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item context and result payload.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      type_r <= req_t'(in_req_type);
      fn_r   <= in_frame_number;
    end
    op_frame_r <= op_frame_nxt;
    push_hot_r <= push_hot_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_frame_r <= ev_frame_nxt;
    ev_hot_r   <= ev_hot_nxt;
    if (res_load) res_r <= res_nxt;
  end

  // Membership tag memory.
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (tag_re) begin
      tag_q_r   <= tag_mem[rd_addr];
      tag_hit_r <= tag_we && (tag_wa == rd_addr);
      tag_bd_r  <= tag_wd;
    end
  end

  // Toward-head link memory.
  always_ff @(posedge clk) begin
    if (lh_we) lh_mem[lh_wa] <= lh_wd;
    if (link_re) begin
      lh_q_r   <= lh_mem[rd_addr];
      lh_hit_r <= lh_we && (lh_wa == rd_addr);
      lh_bd_r  <= lh_wd;
    end
  end

  // Toward-tail link memory.
  always_ff @(posedge clk) begin
    if (lt_we) lt_mem[lt_wa] <= lt_wd;
    if (link_re) begin
      lt_q_r   <= lt_mem[rd_addr];
      lt_hit_r <= lt_we && (lt_wa == rd_addr);
      lt_bd_r  <= lt_wd;
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_COLD_CAP: prdata = PDATA_W'(cold_cap_r);
      REG_HOT_CAP:  prdata = PDATA_W'(hot_cap_r);
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign out_valid            = out_valid_r;
  assign out_assigned_frame   = res_r.assigned_frame;
  assign out_evict_valid      = res_r.evict_valid;
  assign out_evicted_frame    = res_r.evicted_frame;
  assign out_evicted_from_hot = res_r.evicted_from_hot;
  assign out_error_code       = res_r.error_code;
  assign out_resident_count   = res_r.resident_count;

  // The two lists together never hold more frames than exist.
  a_resident_bound: assert property (@(posedge clk) disable iff (!rst_n)
    resident(cold_r, hot_r) <= RES_W'(NUM_FRAMES))
    else $error("resident frame count exceeds the number of frames");

  // An accepted item is decoded in the following cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_FIRST))
    else $error("accepted item was not decoded");

  // No result can appear while the tag memory is still being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result presented during the clearing pass");

  // An error result never reports an eviction.
  a_err_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.error_code != ERR_OK) |-> !res_r.evict_valid)
    else $error("error result carries an eviction");

  // The victim stage is only entered with an eviction pending.
  a_vict_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VICT) |-> ev_valid_r)
    else $error("victim stage without a pending eviction");

endmodule
